### rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants for the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package mlfq_pkg;

    localparam int DEF_SLOTS = 64;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_PICK  = 2'd1;
    localparam logic [1:0] KIND_STATE = 2'd2;
    localparam logic [1:0] KIND_PRIO  = 2'd3;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_USED     = 3'd1;
    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_RUNNABLE = 3'd3;
    localparam logic [2:0] ST_RUNNING  = 3'd4;
    localparam logic [2:0] ST_ZOMBIE   = 3'd5;

    localparam logic [1:0] LVL_MAX      = 2'd2;
    localparam logic [3:0] MAX_PRIO     = 4'd9;
    localparam logic [3:0] DEFAULT_PRIO = 4'd5;

    localparam logic [2:0] REG_KEY_MODE = 3'd0;
    localparam logic [2:0] REG_BOOST    = 3'd1;
    localparam logic [2:0] REG_QTOP     = 3'd2;
    localparam logic [2:0] REG_QMID     = 3'd3;
    localparam logic [2:0] REG_QBOT     = 3'd4;

    localparam logic        RST_KEY_MODE = 1'b1;
    localparam logic [15:0] RST_BOOST    = 16'd100;
    localparam logic [7:0]  RST_QTOP     = 8'd1;
    localparam logic [7:0]  RST_QMID     = 8'd2;
    localparam logic [7:0]  RST_QBOT     = 8'd4;

    typedef struct packed {
        logic [2:0]  state;
        logic [3:0]  prio;
        logic [1:0]  level;
        logic [7:0]  used;
        logic [31:0] stamp;
    } slot_rec_t;

    localparam slot_rec_t RST_REC = '{state: ST_UNUSED, prio: DEFAULT_PRIO,
                                      level: 2'd0, used: 8'd0, stamp: 32'd0};

    typedef struct packed {
        logic        key_mode;
        logic [15:0] boost_period;
        logic [7:0]  q_top;
        logic [7:0]  q_mid;
        logic [7:0]  q_bot;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic fetch;
        logic exec;
        logic scan;
        logic drain;
        logic dispatch;
    } cmd_t;

    typedef struct packed {
        logic req_pick;
        logic scan_last;
    } status_t;

endpackage
`default_nettype wire

### rtl/mlfq_ctrl.sv
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: single-slot access or full table scan for a pick.
// ----------------------------------------------------------------------------
`default_nettype none
module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t st,
    output cmd_t         cmd,
    output logic         busy
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_FETCH    = 6'b000010,
        S_EXEC     = 6'b000100,
        S_SCAN     = 6'b001000,
        S_DRAIN    = 6'b010000,
        S_DISPATCH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = st.req_pick ? S_SCAN : S_FETCH;
                end
            end
            S_FETCH:    state_next = S_EXEC;
            S_EXEC:     state_next = S_IDLE;
            S_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:    state_next = S_DISPATCH;
            S_DISPATCH: state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign cmd.load     = (state_reg == S_IDLE) && start;
    assign cmd.fetch    = (state_reg == S_FETCH);
    assign cmd.exec     = (state_reg == S_EXEC);
    assign cmd.scan     = (state_reg == S_SCAN);
    assign cmd.drain    = (state_reg == S_DRAIN);
    assign cmd.dispatch = (state_reg == S_DISPATCH);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !busy)
        else $error("single-slot request did not finish");

    a_dispatch_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dispatch |=> !busy)
        else $error("pick did not finish after dispatch");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan && st.scan_last |=> cmd.drain)
        else $error("scan end not followed by drain");

endmodule
`default_nettype wire

### rtl/mlfq_dp.sv
// ----------------------------------------------------------------------------
// mlfq_dp
// Slot table, counters, charge/boost/select logic and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module mlfq_dp
    import mlfq_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd,
    input  wire cfg_t       cfg,
    input  wire logic [1:0] kind,
    input  wire logic [5:0] slot,
    input  wire logic       has_current,
    input  wire logic [2:0] new_state,
    input  wire logic [3:0] new_priority,
    output status_t         st,
    output logic            done,
    output logic [5:0]      picked_slot,
    output logic            found,
    output logic            error,
    output logic [1:0]      slot_level,
    output logic            boosted
);

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    slot_rec_t mem [SLOTS];
    logic [SLOTS-1:0] vld_reg;
    slot_rec_t rdata_reg;
    logic      rvld_reg;

    logic [1:0]  kind_reg;
    logic [5:0]  slot_reg;
    logic        hasc_reg;
    logic [2:0]  nst_reg;
    logic [3:0]  npr_reg;
    logic        boost_reg;
    logic [31:0] tick_reg;
    logic [31:0] last_boost_reg;
    logic [31:0] dcount_reg;

    logic [IDXW-1:0] cnt_reg;
    logic            proc_reg;
    logic [IDXW-1:0] pidx_reg;
    logic            have_reg;
    logic [IDXW-1:0] best_reg;
    slot_rec_t       best_rec_reg;
    logic [3:0]      bkey_reg;

    logic        done_reg;
    logic [5:0]  picked_reg;
    logic        found_reg;
    logic        error_reg;
    logic [1:0]  level_reg;
    logic        boosted_reg;

    logic            slot_ok;
    logic [IDXW-1:0] slot_idx;
    logic [IDXW-1:0] rd_addr;
    slot_rec_t       rec_in;
    slot_rec_t       rec_new;
    slot_rec_t       rec_scan;
    logic            we;
    logic [IDXW-1:0] wa;
    slot_rec_t       wd;
    logic [7:0]      quant;
    logic [8:0]      used_inc;
    logic            err_c;
    logic [3:0]      key_c;
    logic            better;

    assign slot_ok  = (32'(slot_reg) < SLOTS);
    assign slot_idx = IDXW'(slot_reg);
    assign rd_addr  = cmd.scan ? cnt_reg : slot_idx;
    assign rec_in   = rvld_reg ? rdata_reg : RST_REC;

    assign st.req_pick  = (kind == KIND_PICK);
    assign st.scan_last = (cnt_reg == IDXW'(SLOTS - 1));

    // single-slot update
    always_comb
    begin
        rec_new  = rec_in;
        err_c    = 1'b0;
        quant    = 8'd0;
        used_inc = 9'd0;
        case (kind_reg)
            KIND_TICK:
            begin
                if (hasc_reg)
                begin
                    case (rec_in.level)
                        2'd0:    quant = cfg.q_top;
                        2'd1:    quant = cfg.q_mid;
                        default: quant = cfg.q_bot;
                    endcase
                    if (quant == 8'd0)
                    begin
                        quant = 8'd1;
                    end
                    used_inc = (rec_in.used == 8'hff) ? 9'h0ff : {1'b0, rec_in.used} + 9'd1;
                    if (used_inc >= {1'b0, quant})
                    begin
                        if (rec_in.level < LVL_MAX)
                        begin
                            rec_new.level = rec_in.level + 2'd1;
                        end
                        rec_new.used = 8'd0;
                    end
                    else
                    begin
                        rec_new.used = used_inc[7:0];
                    end
                end
            end
            KIND_STATE:
            begin
                if (nst_reg <= ST_ZOMBIE)
                begin
                    rec_new.state = nst_reg;
                    if (nst_reg == ST_USED)
                    begin
                        rec_new.prio  = DEFAULT_PRIO;
                        rec_new.level = 2'd0;
                        rec_new.used  = 8'd0;
                        rec_new.stamp = 32'd0;
                    end
                    else if (nst_reg == ST_SLEEPING)
                    begin
                        rec_new.used = 8'd0;
                    end
                end
            end
            KIND_PRIO:
            begin
                if (npr_reg > MAX_PRIO || rec_in.state == ST_UNUSED)
                begin
                    err_c = 1'b1;
                end
                else
                begin
                    rec_new.prio = npr_reg;
                end
            end
            default: rec_new = rec_in;
        endcase
    end

    // scan element: boost then compare
    always_comb
    begin
        rec_scan = rec_in;
        if (boost_reg && rec_in.state != ST_UNUSED)
        begin
            rec_scan.level = 2'd0;
            rec_scan.used  = 8'd0;
        end
        key_c  = cfg.key_mode ? {2'b00, rec_scan.level} : rec_scan.prio;
        better = (rec_scan.state == ST_RUNNABLE) &&
                 (!have_reg || key_c < bkey_reg ||
                  (key_c == bkey_reg && rec_scan.stamp < best_rec_reg.stamp));
    end

    always_comb
    begin
        we = 1'b0;
        wa = slot_idx;
        wd = rec_new;
        if (cmd.exec)
        begin
            we = slot_ok;
        end
        else if (proc_reg)
        begin
            we = boost_reg;
            wa = pidx_reg;
            wd = rec_scan;
        end
        else if (cmd.dispatch)
        begin
            we       = have_reg;
            wa       = best_reg;
            wd       = best_rec_reg;
            wd.state = ST_RUNNING;
            wd.stamp = dcount_reg + 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            rvld_reg       <= 1'b0;
            kind_reg       <= KIND_TICK;
            boost_reg      <= 1'b0;
            tick_reg       <= 32'd0;
            last_boost_reg <= 32'd0;
            dcount_reg     <= 32'd0;
            cnt_reg        <= '0;
            proc_reg       <= 1'b0;
            have_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[wa] <= 1'b1;
            end
            rvld_reg <= vld_reg[rd_addr];
            proc_reg <= cmd.scan;
            done_reg <= cmd.exec || cmd.dispatch;
            if (cmd.load)
            begin
                kind_reg <= kind;
                cnt_reg  <= '0;
                have_reg <= 1'b0;
                boost_reg <= 1'b0;
                if (kind == KIND_TICK)
                begin
                    tick_reg <= tick_reg + 32'd1;
                end
                if (kind == KIND_PICK &&
                    (tick_reg - last_boost_reg) >= {16'd0, cfg.boost_period})
                begin
                    boost_reg      <= 1'b1;
                    last_boost_reg <= tick_reg;
                end
            end
            if (cmd.scan)
            begin
                cnt_reg <= cnt_reg + IDXW'(1);
            end
            if (proc_reg && better)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.dispatch && have_reg)
            begin
                dcount_reg <= dcount_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            slot_reg <= slot;
            hasc_reg <= has_current;
            nst_reg  <= new_state;
            npr_reg  <= new_priority;
        end
        if (cmd.scan)
        begin
            pidx_reg <= cnt_reg;
        end
        if (proc_reg && better)
        begin
            best_reg     <= pidx_reg;
            best_rec_reg <= rec_scan;
            bkey_reg     <= key_c;
        end
        if (cmd.exec)
        begin
            picked_reg  <= 6'd0;
            found_reg   <= 1'b0;
            boosted_reg <= 1'b0;
            error_reg   <= (kind_reg == KIND_PRIO) && (!slot_ok || err_c);
            level_reg   <= slot_ok ? rec_new.level : 2'd0;
        end
        if (cmd.dispatch)
        begin
            picked_reg  <= have_reg ? 6'(best_reg) : 6'd0;
            found_reg   <= have_reg;
            boosted_reg <= boost_reg;
            error_reg   <= 1'b0;
            level_reg   <= have_reg ? best_rec_reg.level : 2'd0;
        end
    end

    assign done        = done_reg;
    assign picked_slot = picked_reg;
    assign found       = found_reg;
    assign error       = error_reg;
    assign slot_level  = level_reg;
    assign boosted     = boosted_reg;

endmodule
`default_nettype wire

### rtl/multilevel_feedback_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Multilevel feedback queue scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// One request at a time: a tick, state change or priority write passes
// through the fetch and exec states to the done strobe; a pick scans the
// whole slot table through the single read port of the slot memory, one
// slot per cycle, then drains and dispatches. busy is high until the result
// is shown; the result stands on the ports from the one cycle in which done
// is high until the next request ends, and done cannot be held off.
`default_nettype none
module multilevel_feedback_scheduler
    import mlfq_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [5:0]  slot,
    input  wire logic        has_current,
    input  wire logic [2:0]  new_state,
    input  wire logic [3:0]  new_priority,
    output logic             done,
    output logic [5:0]       picked_slot,
    output logic             found,
    output logic             error,
    output logic [1:0]       slot_level,
    output logic             boosted,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t st;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_mode     <= RST_KEY_MODE;
            cfg_reg.boost_period <= RST_BOOST;
            cfg_reg.q_top        <= RST_QTOP;
            cfg_reg.q_mid        <= RST_QMID;
            cfg_reg.q_bot        <= RST_QBOT;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_KEY_MODE: cfg_reg.key_mode     <= pwdata[0];
                REG_BOOST:    cfg_reg.boost_period <= pwdata[15:0];
                REG_QTOP:     cfg_reg.q_top        <= pwdata[7:0];
                REG_QMID:     cfg_reg.q_mid        <= pwdata[7:0];
                REG_QBOT:     cfg_reg.q_bot        <= pwdata[7:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_KEY_MODE: prdata = {31'd0, cfg_reg.key_mode};
            REG_BOOST:    prdata = {16'd0, cfg_reg.boost_period};
            REG_QTOP:     prdata = {24'd0, cfg_reg.q_top};
            REG_QMID:     prdata = {24'd0, cfg_reg.q_mid};
            REG_QBOT:     prdata = {24'd0, cfg_reg.q_bot};
            default:      prdata = 32'd0;
        endcase
    end

    mlfq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    mlfq_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg_reg),
        .kind         (kind),
        .slot         (slot),
        .has_current  (has_current),
        .new_state    (new_state),
        .new_priority (new_priority),
        .st           (st),
        .done         (done),
        .picked_slot  (picked_slot),
        .found        (found),
        .error        (error),
        .slot_level   (slot_level),
        .boosted      (boosted)
    );

endmodule
`default_nettype wire
